// File: src/pbm_pkg.sv
`default_nettype none

package pbm_pkg;

   // Word and permutation geometry
   localparam int WORD_BITS  = 8;
   localparam int PERM_DEPTH = 8;
   localparam int IDX_BITS   = 3;
   localparam int DATA_BITS  = 8;
   localparam int CSR_BITS   = 24;

   // Valid bits of the stored word
   localparam logic [DATA_BITS-1:0] WORD_MASK = DATA_BITS'((1 << WORD_BITS) - 1);

   // Eight 3-bit indexes, entry i in bits 3i+2..3i
   typedef logic [PERM_DEPTH-1:0][IDX_BITS-1:0] index_vec_type;

   localparam index_vec_type  IDENTITY_PERM   = index_vec_type'(24'hFAC688);
   localparam logic [DATA_BITS-1:0] START_BITS_RESET = 8'd15;

   // Request operation codes
   typedef enum logic {
      OP_STEP    = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_PERM_X     = 2'd0,
      CSR_START_PERM = 2'd1,
      CSR_START_BITS = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   // Bit read that returns zero above the word
   function automatic logic bit_at(logic [DATA_BITS-1:0] w, logic [IDX_BITS-1:0] idx);
      return (int'(idx) < WORD_BITS) ? w[idx] : 1'b0;
   endfunction

endpackage

`default_nettype wire

// File: src/pbm_mix.sv
`default_nettype none

// In-order XOR pass over the word, then the swap chain for the output value
module pbm_mix (
   input  wire logic [pbm_pkg::DATA_BITS-1:0] word_i,
   input  wire pbm_pkg::index_vec_type        perm_i,
   input  wire pbm_pkg::index_vec_type        swap_i,
   output logic      [pbm_pkg::DATA_BITS-1:0] word_o,
   output logic      [pbm_pkg::DATA_BITS-1:0] value_o
);

   logic [pbm_pkg::DATA_BITS-1:0] xor_word;

   // XOR pass: each bit sees the bits already updated
   always_comb begin
      logic [pbm_pkg::DATA_BITS-1:0] w;
      w = word_i & pbm_pkg::WORD_MASK;
      for (int i = 0; i < pbm_pkg::WORD_BITS; i++) begin
         w[i] = w[i] ^ pbm_pkg::bit_at(w, perm_i[i]);
      end
      xor_word = w & pbm_pkg::WORD_MASK;
   end

   assign word_o = xor_word;

   // Swap chain: bit i exchanged with bit swap_i[i], out-of-word indexes ignored
   always_comb begin
      logic [pbm_pkg::DATA_BITS-1:0] v;
      logic                          t;
      v = xor_word;
      t = 1'b0;
      for (int i = 0; i < pbm_pkg::WORD_BITS; i++) begin
         if (int'(swap_i[i]) < pbm_pkg::WORD_BITS) begin
            t              = v[i];
            v[i]           = v[swap_i[i]];
            v[swap_i[i]]   = t;
         end
      end
      value_o = v & pbm_pkg::WORD_MASK;
   end

endmodule

`default_nettype wire

// File: src/pbm_conj.sv
`default_nettype none

// Next permutation: x o perm o x^-1
module pbm_conj (
   input  wire pbm_pkg::index_vec_type perm_x_i,
   input  wire pbm_pkg::index_vec_type perm_i,
   output pbm_pkg::index_vec_type      perm_o
);

   pbm_pkg::index_vec_type inv;

   // Inverse of x: highest i wins, entries never named stay zero
   always_comb begin
      inv = '0;
      for (int i = 0; i < pbm_pkg::PERM_DEPTH; i++) begin
         inv[perm_x_i[i]] = pbm_pkg::IDX_BITS'(i);
      end
   end

   // Conjugate
   always_comb begin
      for (int i = 0; i < pbm_pkg::PERM_DEPTH; i++) begin
         perm_o[i] = perm_x_i[perm_i[inv[i]]];
      end
   end

endmodule

`default_nettype wire

// File: src/permutation_bit_mixing_generator_unit.sv
// Channel   Handshake                Payload
// req       req_valid / req_ready    req_operation, req_swap_0 .. req_swap_7
// rsp       rsp_valid / rsp_ready    rsp_random_value
// csr       csr_valid / csr_ready    csr_index, csr_data
//
// One request per cycle unless a step request waits behind a stalled result. An accepted
// request sits in the input register; a step request then writes the result register,
// from which the result is taken. Restart gives no result.
// The XOR pass, swap chain and conjugation sit between the input and result
// registers and update the state in the same cycle the result is written.
// Reset is synchronous; all state returns to its start values, csr is always ready.
// A stalled result holds the input register only for step requests.
`default_nettype none

module permutation_bit_mixing_generator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_operation,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_0,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_1,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_2,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_3,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_4,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_5,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_6,
   input  wire logic [pbm_pkg::IDX_BITS-1:0]      req_swap_7,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [pbm_pkg::DATA_BITS-1:0]     rsp_random_value,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [pbm_pkg::CSR_BITS-1:0]      csr_data
);

   // Configuration registers
   pbm_pkg::index_vec_type          perm_x_ff;
   pbm_pkg::index_vec_type          start_perm_ff;
   logic [pbm_pkg::DATA_BITS-1:0]   start_bits_ff;

   // State
   logic [pbm_pkg::DATA_BITS-1:0]   bits_ff;
   pbm_pkg::index_vec_type          perm_ff;

   // Input register
   logic                            in_valid_ff;
   pbm_pkg::op_type                 in_op_ff;
   pbm_pkg::index_vec_type          in_swap_ff;

   // Result register
   logic                            out_valid_ff;
   logic [pbm_pkg::DATA_BITS-1:0]   out_value_ff;

   logic                            advance;
   logic                            step_fire;
   logic                            restart_fire;
   logic [pbm_pkg::DATA_BITS-1:0]   mix_word;
   logic [pbm_pkg::DATA_BITS-1:0]   mix_value;
   pbm_pkg::index_vec_type          conj_perm;

   // Handshakes
   assign advance      = in_valid_ff &&
                         (in_op_ff == pbm_pkg::OP_RESTART || !out_valid_ff || rsp_ready);
   assign step_fire    = advance && in_op_ff == pbm_pkg::OP_STEP;
   assign restart_fire = advance && in_op_ff == pbm_pkg::OP_RESTART;
   assign req_ready    = !in_valid_ff || advance;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = out_valid_ff;
   assign rsp_random_value = out_value_ff;

   // Datapath
   pbm_mix u_mix (
      .word_i  (bits_ff),
      .perm_i  (perm_ff),
      .swap_i  (in_swap_ff),
      .word_o  (mix_word),
      .value_o (mix_value)
   );

   pbm_conj u_conj (
      .perm_x_i (perm_x_ff),
      .perm_i   (perm_ff),
      .perm_o   (conj_perm)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         perm_x_ff     <= pbm_pkg::IDENTITY_PERM;
         start_perm_ff <= pbm_pkg::IDENTITY_PERM;
         start_bits_ff <= pbm_pkg::START_BITS_RESET;
      end else if (csr_valid) begin
         unique case (pbm_pkg::csr_index_type'(csr_index))
            pbm_pkg::CSR_PERM_X:     perm_x_ff     <= pbm_pkg::index_vec_type'(csr_data);
            pbm_pkg::CSR_START_PERM: start_perm_ff <= pbm_pkg::index_vec_type'(csr_data);
            pbm_pkg::CSR_START_BITS: start_bits_ff <= csr_data[pbm_pkg::DATA_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff   <= pbm_pkg::op_type'(req_operation);
         in_swap_ff <= {req_swap_7, req_swap_6, req_swap_5, req_swap_4,
                        req_swap_3, req_swap_2, req_swap_1, req_swap_0};
      end
   end

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= pbm_pkg::START_BITS_RESET & pbm_pkg::WORD_MASK;
         perm_ff <= pbm_pkg::IDENTITY_PERM;
      end else if (restart_fire) begin
         bits_ff <= start_bits_ff & pbm_pkg::WORD_MASK;
         perm_ff <= start_perm_ff;
      end else if (step_fire) begin
         bits_ff <= mix_word;
         perm_ff <= conj_perm;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_value_ff <= mix_value;
      end
   end

endmodule

`default_nettype wire

// File: src/pbm_checker.sv
`default_nettype none

module pbm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_operation,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pbm_pkg::DATA_BITS-1:0] rsp_random_value
);

   // A result left waiting stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
      else $error("result dropped or changed while stalled");

   // Requests are refused only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a stalled result");

   // A new result follows an accepted step request through the input and result registers
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && req_operation == pbm_pkg::OP_STEP, 2))
      else $error("result without a matching step request");

   // No result right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind permutation_bit_mixing_generator_unit pbm_checker u_pbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_random_value (rsp_random_value)
);

`default_nettype wire
